>>> design/bfsa_pkg.sv
// Shared types, widths and codes for the best-fit segment allocator.
`default_nettype none
package bfsa_pkg;

   // Table geometry and field widths.
   localparam int MAX_SEG = 32;
   localparam int IDX_W   = $clog2(MAX_SEG);
   localparam int CNT_W   = $clog2(MAX_SEG + 1);
   localparam int ID_W    = 16;
   localparam int OWN_W   = ID_W + 1;
   localparam int LEN_W   = 16;
   localparam int ST_W    = 3;

   localparam logic [OWN_W-1:0] FREE_TAG  = {1'b1, {ID_W{1'b0}}};
   localparam logic [LEN_W-1:0] RESET_MEM = LEN_W'(256);

   // Result status codes.
   localparam logic [ST_W-1:0] ST_ALLOC   = 3'd0;
   localparam logic [ST_W-1:0] ST_COMPACT = 3'd1;
   localparam logic [ST_W-1:0] ST_FREED   = 3'd2;
   localparam logic [ST_W-1:0] ST_NOSPACE = 3'd3;
   localparam logic [ST_W-1:0] ST_IDNF    = 3'd4;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd5;

   // Datapath operation codes.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_LATCH = 4'd1;
   localparam logic [OP_W-1:0] OP_SCAN  = 4'd2;
   localparam logic [OP_W-1:0] OP_ADV   = 4'd3;
   localparam logic [OP_W-1:0] OP_PLACE = 4'd4;
   localparam logic [OP_W-1:0] OP_CINIT = 4'd5;
   localparam logic [OP_W-1:0] OP_CSTEP = 4'd6;
   localparam logic [OP_W-1:0] OP_CAPND = 4'd7;
   localparam logic [OP_W-1:0] OP_RMARK = 4'd8;
   localparam logic [OP_W-1:0] OP_MNEXT = 4'd9;
   localparam logic [OP_W-1:0] OP_MPREV = 4'd10;
   localparam logic [OP_W-1:0] OP_AVGZ  = 4'd11;
   localparam logic [OP_W-1:0] OP_DIVGO = 4'd12;
   localparam logic [OP_W-1:0] OP_LOAD  = 4'd13;

   // Table read address selection.
   localparam logic [1:0] RD_PTR  = 2'd0;
   localparam logic [1:0] RD_NEXT = 2'd1;
   localparam logic [1:0] RD_PREV = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      rd_sel;
      logic            st_we;
      logic [ST_W-1:0] st;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic req_zero;
      logic at_end;
      logic next_ok;
      logic prev_ok;
      logic rd_free;
      logic id_match;
      logic found;
      logic exact;
      logic full;
      logic short_free;
      logic holes_zero;
      logic div_done;
      logic rsp_valid;
   } sts_type;

endpackage
`default_nettype wire

>>> design/bfsa_div.sv
// Restoring divider, one quotient bit per cycle, for the average hole size.
`default_nettype none
module bfsa_div
   import bfsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [LEN_W:0]    dividend,
   input  wire logic [CNT_W-1:0]  divisor,
   output logic                   done,
   output logic [LEN_W-1:0]       quotient
);

   localparam int STEPS = LEN_W + 1;
   localparam int SC_W  = $clog2(STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SC_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [LEN_W:0]    quo_ff, quo_in;
   logic [CNT_W:0]    trial;
   logic              ge;

   // Shift one dividend bit into the partial remainder and try a subtract.
   always_comb begin
      trial   = {rem_ff, quo_ff[LEN_W]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = SC_W'(STEPS - 1);
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? CNT_W'(trial - {1'b0, den_ff}) : trial[CNT_W-1:0];
         quo_in = {quo_ff[LEN_W-1:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[LEN_W-1:0];

endmodule
`default_nettype wire

>>> design/bfsa_dpath.sv
// Segment table, counters, walk pointer and result registers.
`default_nettype none
module bfsa_dpath
   import bfsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic              cfg_we,
   input  wire logic [LEN_W-1:0]  cfg_data,
   output logic [LEN_W-1:0]       mem_size,
   input  wire logic              in_mode,
   input  wire logic [ID_W-1:0]   in_proc_id,
   input  wire logic [LEN_W-1:0]  in_req_size,
   input  wire logic              out_stall,
   output logic                   out_valid,
   output logic [ST_W-1:0]        out_status,
   output logic [LEN_W-1:0]       out_address,
   output logic [LEN_W-1:0]       out_free_total,
   output logic [CNT_W-1:0]       out_hole_count,
   output logic [LEN_W-1:0]       out_avg_hole_size
);

   logic [OWN_W-1:0] own_ff [MAX_SEG];
   logic [OWN_W-1:0] own_in [MAX_SEG];
   logic [LEN_W-1:0] len_ff [MAX_SEG];
   logic [LEN_W-1:0] len_in [MAX_SEG];

   logic [LEN_W-1:0] ms_ff, ms_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] holes_ff, holes_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] acc_ff, acc_in;
   logic             mode_ff, mode_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [LEN_W-1:0] req_ff, req_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [LEN_W-1:0] blen_ff, blen_in;
   logic [LEN_W-1:0] bstart_ff, bstart_in;
   logic [LEN_W-1:0] tmp_ff, tmp_in;
   logic [ST_W-1:0]  st_ff, st_in;
   logic [LEN_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0] avg_ff, avg_in;

   logic             rv_ff, rv_in;
   logic [ST_W-1:0]  rst_ff, rst_in;
   logic [LEN_W-1:0] raddr_ff, raddr_in;
   logic [LEN_W-1:0] rfree_ff, rfree_in;
   logic [CNT_W-1:0] rholes_ff, rholes_in;
   logic [LEN_W-1:0] ravg_ff, ravg_in;

   logic [IDX_W-1:0] pidx, nidx, pvidx, rd_idx, bnidx;
   logic [OWN_W-1:0] rd_own;
   logic [LEN_W-1:0] rd_len;
   logic             rd_free, scan_hit;
   logic             div_done;
   logic [LEN_W-1:0] div_q;
   logic [LEN_W:0]   div_num;

   // One table read a cycle, at the pointer or one of its neighbors.
   always_comb begin
      pidx  = ptr_ff[IDX_W-1:0];
      nidx  = pidx + 1'b1;
      pvidx = pidx - 1'b1;
      bnidx = best_ff + 1'b1;
      case (cmd.rd_sel)
         RD_NEXT: rd_idx = nidx;
         RD_PREV: rd_idx = pvidx;
         default: rd_idx = pidx;
      endcase
      rd_own   = own_ff[rd_idx];
      rd_len   = len_ff[rd_idx];
      rd_free  = rd_own == FREE_TAG;
      scan_hit = rd_free && (rd_len >= req_ff) && (!found_ff || rd_len < blen_ff);
   end

   // Status flags for the controller.
   always_comb begin
      sts.mode       = mode_ff;
      sts.req_zero   = req_ff == '0;
      sts.at_end     = ptr_ff == count_ff;
      sts.next_ok    = ({1'b0, ptr_ff} + 1'b1) < {1'b0, count_ff};
      sts.prev_ok    = ptr_ff != '0;
      sts.rd_free    = rd_free;
      sts.id_match   = rd_own == {1'b0, id_ff};
      sts.found      = found_ff;
      sts.exact      = blen_ff == req_ff;
      sts.full       = count_ff == CNT_W'(MAX_SEG);
      sts.short_free = free_ff < req_ff;
      sts.holes_zero = holes_ff == '0;
      sts.div_done   = div_done;
      sts.rsp_valid  = rv_ff;
   end

   // Table updates: each entry takes its own value, a neighbor's on a
   // shift, or new data where an operation writes it.
   always_comb begin
      for (int k = 0; k < MAX_SEG; k++) begin
         own_in[k] = own_ff[k];
         len_in[k] = len_ff[k];
      end
      unique case (cmd.op)
         OP_PLACE: begin
            if (blen_ff != req_ff) begin
               for (int k = 1; k < MAX_SEG; k++) begin
                  if (k > int'(best_ff) + 1) begin
                     own_in[k] = own_ff[k-1];
                     len_in[k] = len_ff[k-1];
                  end
               end
               own_in[bnidx] = FREE_TAG;
               len_in[bnidx] = blen_ff - req_ff;
               len_in[best_ff] = req_ff;
            end
            own_in[best_ff] = {1'b0, id_ff};
         end
         OP_CSTEP: begin
            if (rd_free) begin
               for (int k = 0; k < MAX_SEG - 1; k++) begin
                  if (k >= int'(pidx)) begin
                     own_in[k] = own_ff[k+1];
                     len_in[k] = len_ff[k+1];
                  end
               end
            end
         end
         OP_CAPND: begin
            own_in[pidx] = FREE_TAG;
            len_in[pidx] = free_ff;
         end
         OP_RMARK: own_in[pidx] = FREE_TAG;
         OP_MNEXT: begin
            for (int k = 0; k < MAX_SEG - 1; k++) begin
               if (k >= int'(nidx)) begin
                  own_in[k] = own_ff[k+1];
                  len_in[k] = len_ff[k+1];
               end
            end
            len_in[pidx] = tmp_ff + rd_len;
         end
         OP_MPREV: begin
            for (int k = 0; k < MAX_SEG - 1; k++) begin
               if (k >= int'(pidx)) begin
                  own_in[k] = own_ff[k+1];
                  len_in[k] = len_ff[k+1];
               end
            end
            len_in[pvidx] = rd_len + tmp_ff;
         end
         default: ;
      endcase
      if (cfg_we) begin
         own_in[0] = FREE_TAG;
         len_in[0] = cfg_data;
      end
   end

   // Scalar state updates.
   always_comb begin
      ms_in     = ms_ff;
      count_in  = count_ff;
      free_in   = free_ff;
      holes_in  = holes_ff;
      ptr_in    = ptr_ff;
      acc_in    = acc_ff;
      mode_in   = mode_ff;
      id_in     = id_ff;
      req_in    = req_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      blen_in   = blen_ff;
      bstart_in = bstart_ff;
      tmp_in    = tmp_ff;
      addr_in   = addr_ff;
      avg_in    = div_done ? div_q : avg_ff;
      st_in     = cmd.st_we ? cmd.st : st_ff;
      unique case (cmd.op)
         OP_LATCH: begin
            mode_in  = in_mode;
            id_in    = in_proc_id;
            req_in   = in_req_size;
            ptr_in   = '0;
            acc_in   = '0;
            found_in = 1'b0;
            addr_in  = '0;
         end
         OP_SCAN: begin
            if (scan_hit) begin
               best_in   = pidx;
               blen_in   = rd_len;
               bstart_in = acc_ff;
               found_in  = 1'b1;
            end
            acc_in = acc_ff + rd_len;
            ptr_in = ptr_ff + 1'b1;
         end
         OP_ADV: begin
            acc_in = acc_ff + rd_len;
            ptr_in = ptr_ff + 1'b1;
         end
         OP_PLACE: begin
            addr_in = bstart_ff;
            free_in = free_ff - req_ff;
            if (blen_ff == req_ff) begin
               holes_in = holes_ff - 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_CINIT: begin
            ptr_in = '0;
            acc_in = '0;
         end
         OP_CSTEP: begin
            if (rd_free) begin
               count_in = count_ff - 1'b1;
            end else begin
               acc_in = acc_ff + rd_len;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         OP_CAPND: begin
            count_in  = count_ff + 1'b1;
            holes_in  = CNT_W'(1);
            best_in   = pidx;
            blen_in   = free_ff;
            bstart_in = acc_ff;
         end
         OP_RMARK: begin
            free_in  = free_ff + rd_len;
            holes_in = holes_ff + 1'b1;
            tmp_in   = rd_len;
            addr_in  = acc_ff;
         end
         OP_MNEXT: begin
            tmp_in   = tmp_ff + rd_len;
            count_in = count_ff - 1'b1;
            holes_in = holes_ff - 1'b1;
         end
         OP_MPREV: begin
            count_in = count_ff - 1'b1;
            holes_in = holes_ff - 1'b1;
         end
         OP_AVGZ: avg_in = '0;
         default: ;
      endcase
      if (cfg_we) begin
         ms_in    = cfg_data;
         count_in = (cfg_data != '0) ? CNT_W'(1) : '0;
         holes_in = (cfg_data != '0) ? CNT_W'(1) : '0;
         free_in  = cfg_data;
      end
   end

   // Output register: holds a result until taken, so work can go on.
   always_comb begin
      rst_in    = rst_ff;
      raddr_in  = raddr_ff;
      rfree_in  = rfree_ff;
      rholes_in = rholes_ff;
      ravg_in   = ravg_ff;
      rv_in     = rv_ff && out_stall;
      if (cmd.op == OP_LOAD) begin
         rv_in     = 1'b1;
         rst_in    = st_ff;
         raddr_in  = addr_ff;
         rfree_in  = free_ff;
         rholes_in = holes_ff;
         ravg_in   = avg_ff;
      end
   end

   assign div_num = {1'b0, free_ff} + (LEN_W+1)'(holes_ff) - 1'b1;

   bfsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIVGO),
      .dividend (div_num),
      .divisor  (holes_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Control state with reset; the table keeps only entry 0 defined.
   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff     <= RESET_MEM;
         count_ff  <= CNT_W'(1);
         free_ff   <= RESET_MEM;
         holes_ff  <= CNT_W'(1);
         rv_ff     <= 1'b0;
         own_ff[0] <= FREE_TAG;
         len_ff[0] <= RESET_MEM;
      end else begin
         ms_ff    <= ms_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         holes_ff <= holes_in;
         rv_ff    <= rv_in;
         own_ff   <= own_in;
         len_ff   <= len_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      acc_ff    <= acc_in;
      mode_ff   <= mode_in;
      id_ff     <= id_in;
      req_ff    <= req_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      blen_ff   <= blen_in;
      bstart_ff <= bstart_in;
      tmp_ff    <= tmp_in;
      st_ff     <= st_in;
      addr_ff   <= addr_in;
      avg_ff    <= avg_in;
      rst_ff    <= rst_in;
      raddr_ff  <= raddr_in;
      rfree_ff  <= rfree_in;
      rholes_ff <= rholes_in;
      ravg_ff   <= ravg_in;
   end

   assign mem_size          = ms_ff;
   assign out_valid         = rv_ff;
   assign out_status        = rst_ff;
   assign out_address       = raddr_ff;
   assign out_free_total    = rfree_ff;
   assign out_hole_count    = rholes_ff;
   assign out_avg_hole_size = ravg_ff;

endmodule
`default_nettype wire

>>> design/bfsa_ctrl.sv
// Controller state machine that sequences each item through the datapath.
`default_nettype none
module bfsa_ctrl
   import bfsa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire logic    out_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_SEND  = 4'd3;
   localparam logic [3:0] S_COMP  = 4'd4;
   localparam logic [3:0] S_CPLC  = 4'd5;
   localparam logic [3:0] S_RFIND = 4'd6;
   localparam logic [3:0] S_RNEXT = 4'd7;
   localparam logic [3:0] S_RPREV = 4'd8;
   localparam logic [3:0] S_STAT  = 4'd9;
   localparam logic [3:0] S_DIVW  = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   logic [3:0] state_ff, state_in;

   // Next state and datapath command.
   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.rd_sel = RD_PTR;
      cmd.st_we  = 1'b0;
      cmd.st     = ST_ALLOC;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.mode) begin
               state_in = S_RFIND;
            end else if (sts.req_zero) begin
               cmd.st_we = 1'b1;
               cmd.st    = ST_NOSPACE;
               state_in  = S_STAT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.at_end) begin
               state_in = S_SEND;
            end else begin
               cmd.op = OP_SCAN;
            end
         end
         S_SEND: begin
            cmd.st_we = 1'b1;
            state_in  = S_STAT;
            if (sts.found) begin
               if (!sts.exact && sts.full) begin
                  cmd.st = ST_FULL;
               end else begin
                  cmd.op = OP_PLACE;
                  cmd.st = ST_ALLOC;
               end
            end else if (sts.short_free) begin
               cmd.st = ST_NOSPACE;
            end else begin
               cmd.st_we = 1'b0;
               cmd.op    = OP_CINIT;
               state_in  = S_COMP;
            end
         end
         S_COMP: begin
            if (sts.at_end) begin
               cmd.op   = OP_CAPND;
               state_in = S_CPLC;
            end else begin
               cmd.op = OP_CSTEP;
            end
         end
         S_CPLC: begin
            cmd.op    = OP_PLACE;
            cmd.st_we = 1'b1;
            cmd.st    = ST_COMPACT;
            state_in  = S_STAT;
         end
         S_RFIND: begin
            if (sts.at_end) begin
               cmd.st_we = 1'b1;
               cmd.st    = ST_IDNF;
               state_in  = S_STAT;
            end else if (sts.id_match) begin
               cmd.op    = OP_RMARK;
               cmd.st_we = 1'b1;
               cmd.st    = ST_FREED;
               state_in  = S_RNEXT;
            end else begin
               cmd.op = OP_ADV;
            end
         end
         S_RNEXT: begin
            cmd.rd_sel = RD_NEXT;
            if (sts.next_ok && sts.rd_free) begin
               cmd.op = OP_MNEXT;
            end
            state_in = S_RPREV;
         end
         S_RPREV: begin
            cmd.rd_sel = RD_PREV;
            if (sts.prev_ok && sts.rd_free) begin
               cmd.op = OP_MPREV;
            end
            state_in = S_STAT;
         end
         S_STAT: begin
            if (sts.holes_zero) begin
               cmd.op   = OP_AVGZ;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_DIVGO;
               state_in = S_DIVW;
            end
         end
         S_DIVW: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.rsp_valid || !out_stall) begin
               cmd.op   = OP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_stall = state_ff != S_IDLE;

endmodule
`default_nettype wire

>>> design/best_fit_segment_allocator_core.sv
// Top level of the best-fit segment allocator: APB register, controller and datapath.
// The segment walk (one entry a cycle) and the average divider set the rate.
// One item is in work at a time; the next is taken as soon as the result is registered.
// Synchronous active-high reset: memory size 256, one free hole, no result pending.
`default_nettype none
module best_fit_segment_allocator_core
   import bfsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_mode,
   input  wire logic [ID_W-1:0]   req_proc_id,
   input  wire logic [LEN_W-1:0]  req_req_size,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [ST_W-1:0]        rsp_status,
   output logic [LEN_W-1:0]       rsp_address,
   output logic [LEN_W-1:0]       rsp_free_total,
   output logic [CNT_W-1:0]       rsp_hole_count,
   output logic [LEN_W-1:0]       rsp_avg_hole_size,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   cmd_type          cmd;
   sts_type          sts;
   logic             cfg_we;
   logic [LEN_W-1:0] mem_size;

   // Register decode: memory_size is the only register, at address 0.
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 3'd0);
   assign csr_prdata = (csr_paddr == 3'd0) ? {16'd0, mem_size} : 32'd0;

   bfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .out_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfsa_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg_we            (cfg_we),
      .cfg_data          (csr_pwdata[LEN_W-1:0]),
      .mem_size          (mem_size),
      .in_mode           (req_mode),
      .in_proc_id        (req_proc_id),
      .in_req_size       (req_req_size),
      .out_stall         (rsp_stall),
      .out_valid         (rsp_valid),
      .out_status        (rsp_status),
      .out_address       (rsp_address),
      .out_free_total    (rsp_free_total),
      .out_hole_count    (rsp_hole_count),
      .out_avg_hole_size (rsp_avg_hole_size)
   );

endmodule
`default_nettype wire

>>> design/bfsa_checker.sv
// Port-level checker for the allocator and its bind to the top level.
`default_nettype none
module bfsa_checker
   import bfsa_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [ST_W-1:0]   rsp_status,
   input wire logic [LEN_W-1:0]  rsp_address,
   input wire logic [LEN_W-1:0]  rsp_free_total,
   input wire logic [CNT_W-1:0]  rsp_hole_count,
   input wire logic [LEN_W-1:0]  rsp_avg_hole_size
);

   // A result that is held back keeps its status and address.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address))
      else $error("result changed while stalled");

   // Only one item is in work: the input stalls right after an accept.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in work");

   // Failed requests report address zero.
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOSPACE || rsp_status == ST_IDNF ||
                    rsp_status == ST_FULL) |-> rsp_address == '0)
      else $error("failed request reports an address");

   // No holes means no free space and no average; holes mean a nonzero average.
   a_no_holes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hole_count == '0 |-> rsp_avg_hole_size == '0 && rsp_free_total == '0)
      else $error("empty hole list with free space or average");

   a_holes_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hole_count != '0 |-> rsp_avg_hole_size != '0)
      else $error("holes present but average is zero");

endmodule

bind best_fit_segment_allocator_core bfsa_checker u_bfsa_checker (.*);
`default_nettype wire
